/* hdl/assert_macros.svh */
// Assertion macros shared by the framer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every rising clock edge outside reset.
`define DSFE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds on a rising clock edge outside reset.
`define DSFE_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* hdl/dsfe_pkg.sv */
// Types, constants and helper functions shared by the framer modules.
package dsfe_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int APB_ADDR_W  = 5;
    localparam int APB_DATA_W  = 32;

    localparam logic [2:0] REG_START_CODE  = 3'd0;
    localparam logic [2:0] REG_END_CODE    = 3'd1;
    localparam logic [2:0] REG_ESCAPE_CODE = 3'd2;
    localparam logic [2:0] REG_START_SUB   = 3'd3;
    localparam logic [2:0] REG_END_SUB     = 3'd4;

    localparam logic [7:0] RESET_START_CODE  = 8'd2;
    localparam logic [7:0] RESET_END_CODE    = 8'd3;
    localparam logic [7:0] RESET_ESCAPE_CODE = 8'd16;
    localparam logic [7:0] RESET_START_SUB   = 8'd18;
    localparam logic [7:0] RESET_END_SUB     = 8'd19;

    typedef struct packed {
        logic [7:0] start_code;
        logic [7:0] end_code;
        logic [7:0] escape_code;
        logic [7:0] start_substitute;
        logic [7:0] end_substitute;
    } cfg_t;

    typedef enum logic [1:0] {
        KIND_PLAIN = 2'd0,
        KIND_START = 2'd1,
        KIND_END   = 2'd2,
        KIND_ESC   = 2'd3
    } kind_t;

    typedef struct packed {
        logic [7:0] data;
        kind_t      data_kind;
        logic [7:0] sum;
        kind_t      sum_kind;
        logic       open;
        logic       last;
    } desc_t;

    typedef enum logic [5:0] {
        PH_START = 6'b000001,
        PH_DATA0 = 6'b000010,
        PH_DATA1 = 6'b000100,
        PH_SUM0  = 6'b001000,
        PH_SUM1  = 6'b010000,
        PH_END   = 6'b100000
    } phase_t;

    function automatic kind_t classify(input logic [7:0] b, input cfg_t c);
        kind_t k;
        if (b == c.start_code)
            k = KIND_START;
        else if (b == c.end_code)
            k = KIND_END;
        else if (b == c.escape_code)
            k = KIND_ESC;
        else
            k = KIND_PLAIN;
        return k;
    endfunction

    function automatic logic [7:0] second_byte(input kind_t k, input logic [7:0] b,
                                               input cfg_t c);
        logic [7:0] r;
        case (k)
            KIND_START: r = c.start_substitute;
            KIND_END:   r = c.end_substitute;
            KIND_ESC:   r = c.escape_code;
            default:    r = b;
        endcase
        return r;
    endfunction

endpackage

/* hdl/dsfe_regs.sv */
// Configuration register file behind the APB-style port.
module dsfe_regs
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [dsfe_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [dsfe_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [dsfe_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    output dsfe_pkg::cfg_t                    cfg
);

    dsfe_pkg::cfg_t cfg_reg;
    dsfe_pkg::cfg_t cfg_next;
    logic [2:0]     index;
    logic           wr_en;
    logic [7:0]     rd_byte;

    assign pready = 1'b1;
    assign index  = paddr[4:2];
    assign wr_en  = psel & penable & pwrite & pready;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (index)
                dsfe_pkg::REG_START_CODE:  cfg_next.start_code       = pwdata[7:0];
                dsfe_pkg::REG_END_CODE:    cfg_next.end_code         = pwdata[7:0];
                dsfe_pkg::REG_ESCAPE_CODE: cfg_next.escape_code      = pwdata[7:0];
                dsfe_pkg::REG_START_SUB:   cfg_next.start_substitute = pwdata[7:0];
                dsfe_pkg::REG_END_SUB:     cfg_next.end_substitute   = pwdata[7:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_code       <= dsfe_pkg::RESET_START_CODE;
            cfg_reg.end_code         <= dsfe_pkg::RESET_END_CODE;
            cfg_reg.escape_code      <= dsfe_pkg::RESET_ESCAPE_CODE;
            cfg_reg.start_substitute <= dsfe_pkg::RESET_START_SUB;
            cfg_reg.end_substitute   <= dsfe_pkg::RESET_END_SUB;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (index)
            dsfe_pkg::REG_START_CODE:  rd_byte = cfg_reg.start_code;
            dsfe_pkg::REG_END_CODE:    rd_byte = cfg_reg.end_code;
            dsfe_pkg::REG_ESCAPE_CODE: rd_byte = cfg_reg.escape_code;
            dsfe_pkg::REG_START_SUB:   rd_byte = cfg_reg.start_substitute;
            dsfe_pkg::REG_END_SUB:     rd_byte = cfg_reg.end_substitute;
            default:                   rd_byte = 8'd0;
        endcase
    end

    assign prdata = {{(dsfe_pkg::APB_DATA_W-8){1'b0}}, rd_byte};

endmodule

/* hdl/dsfe_front.sv */
// Input side: accepts payload requests, keeps frame state and checksum, classifies bytes.
`include "assert_macros.svh"

module dsfe_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  dsfe_pkg::cfg_t  cfg,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [7:0]      s_tdata,    // [7:0] payload_byte
    input  logic            s_tlast,    // frame_last
    input  logic            q_full,
    output logic            push,
    output dsfe_pkg::desc_t push_desc
);

    logic       in_frame_reg;
    logic       in_frame_next;
    logic [7:0] sum_reg;
    logic [7:0] sum_next;
    logic [7:0] sum_base;
    logic [7:0] new_sum;

    assign s_tready = !q_full;
    assign push     = s_tvalid & s_tready;
    assign sum_base = in_frame_reg ? sum_reg : 8'd0;
    assign new_sum  = sum_base + s_tdata;

    always_comb
    begin
        push_desc.data      = s_tdata;
        push_desc.data_kind = dsfe_pkg::classify(s_tdata, cfg);
        push_desc.sum       = new_sum;
        push_desc.sum_kind  = dsfe_pkg::classify(new_sum, cfg);
        push_desc.open      = !in_frame_reg;
        push_desc.last      = s_tlast;
    end

    always_comb
    begin
        in_frame_next = in_frame_reg;
        sum_next      = sum_reg;
        if (push)
        begin
            in_frame_next = !s_tlast;
            sum_next      = s_tlast ? 8'd0 : new_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            sum_reg      <= 8'd0;
        end
        else
        begin
            in_frame_reg <= in_frame_next;
            sum_reg      <= sum_next;
        end
    end

    `DSFE_ASSERT(a_close_on_last, clk, rst_n, push && s_tlast |=> !in_frame_reg, "frame left open after last byte")
    `DSFE_ASSERT(a_open_mid_frame, clk, rst_n, push && !s_tlast |=> in_frame_reg, "frame closed before last byte")
    `DSFE_ASSERT(a_open_flag, clk, rst_n, push |-> (push_desc.open == !in_frame_reg), "start flag disagrees with frame state")

endmodule

/* hdl/dsfe_queue.sv */
// Short request queue between the front and back halves.
`include "assert_macros.svh"

module dsfe_queue
#(
    parameter int DEPTH = dsfe_pkg::QUEUE_DEPTH
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  dsfe_pkg::desc_t push_desc,
    input  logic            pop,
    output logic            valid,
    output logic            full,
    output dsfe_pkg::desc_t head
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    dsfe_pkg::desc_t  mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign valid = count_reg != '0;
    assign full  = count_reg == CNT_W'(DEPTH);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_desc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `DSFE_NEVER(a_push_full, clk, rst_n, push && full, "push into full queue")
    `DSFE_NEVER(a_pop_empty, clk, rst_n, pop && !valid, "pop from empty queue")
    `DSFE_ASSERT(a_count_bound, clk, rst_n, count_reg <= CNT_W'(DEPTH), "queue count overflow")

endmodule

/* hdl/dsfe_back.sv */
// Output side: expands each queued request into framed, stuffed line bytes.
`include "assert_macros.svh"

module dsfe_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  dsfe_pkg::cfg_t  cfg,
    input  logic            q_valid,
    input  dsfe_pkg::desc_t head,
    output logic            pop,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [7:0]      m_tdata,    // [7:0] line_byte
    output logic            m_tlast,    // run_last
    output logic            m_tuser     // frame_done
);

    dsfe_pkg::phase_t phase_reg;
    dsfe_pkg::phase_t phase_next;
    dsfe_pkg::phase_t cur_phase;
    dsfe_pkg::phase_t step_phase;
    logic             advance;
    logic             finish;
    logic             done;
    logic [7:0]       line_byte;
    logic             tvalid_reg;
    logic             tvalid_next;
    logic [7:0]       tdata_reg;
    logic             tlast_reg;
    logic             tuser_reg;

    assign cur_phase = (phase_reg == dsfe_pkg::PH_START && !head.open) ?
                       dsfe_pkg::PH_DATA0 : phase_reg;

    always_comb
    begin
        line_byte  = head.data;
        step_phase = dsfe_pkg::PH_START;
        finish     = 1'b0;
        done       = 1'b0;
        case (cur_phase)
            dsfe_pkg::PH_START:
            begin
                line_byte  = cfg.start_code;
                step_phase = dsfe_pkg::PH_DATA0;
            end
            dsfe_pkg::PH_DATA0:
            begin
                if (head.data_kind != dsfe_pkg::KIND_PLAIN)
                begin
                    line_byte  = cfg.escape_code;
                    step_phase = dsfe_pkg::PH_DATA1;
                end
                else
                begin
                    line_byte = head.data;
                    if (head.last)
                        step_phase = dsfe_pkg::PH_SUM0;
                    else
                        finish = 1'b1;
                end
            end
            dsfe_pkg::PH_DATA1:
            begin
                line_byte = dsfe_pkg::second_byte(head.data_kind, head.data, cfg);
                if (head.last)
                    step_phase = dsfe_pkg::PH_SUM0;
                else
                    finish = 1'b1;
            end
            dsfe_pkg::PH_SUM0:
            begin
                if (head.sum_kind != dsfe_pkg::KIND_PLAIN)
                begin
                    line_byte  = cfg.escape_code;
                    step_phase = dsfe_pkg::PH_SUM1;
                end
                else
                begin
                    line_byte  = head.sum;
                    step_phase = dsfe_pkg::PH_END;
                end
            end
            dsfe_pkg::PH_SUM1:
            begin
                line_byte  = dsfe_pkg::second_byte(head.sum_kind, head.sum, cfg);
                step_phase = dsfe_pkg::PH_END;
            end
            dsfe_pkg::PH_END:
            begin
                line_byte = cfg.end_code;
                finish    = 1'b1;
                done      = 1'b1;
            end
            default:
            begin
                finish = 1'b1;
            end
        endcase
    end

    assign advance = q_valid && (!tvalid_reg || m_tready);
    assign pop     = advance && finish;

    always_comb
    begin
        phase_next = phase_reg;
        if (advance)
            phase_next = finish ? dsfe_pkg::PH_START : step_phase;
    end

    always_comb
    begin
        tvalid_next = tvalid_reg;
        if (advance)
            tvalid_next = 1'b1;
        else if (m_tready)
            tvalid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= dsfe_pkg::PH_START;
            tvalid_reg <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            tvalid_reg <= tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            tdata_reg <= line_byte;
            tlast_reg <= finish;
            tuser_reg <= done;
        end
    end

    assign m_tvalid = tvalid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tlast  = tlast_reg;
    assign m_tuser  = tuser_reg;

    `DSFE_ASSERT(a_done_is_last, clk, rst_n, tvalid_reg && tuser_reg |-> tlast_reg, "end code not last of its run")
    `DSFE_ASSERT(a_no_pop_stalled, clk, rst_n, tvalid_reg && !m_tready |-> !pop, "request retired while output stalled")
    `DSFE_ASSERT(a_idle_phase, clk, rst_n, !q_valid |-> phase_reg == dsfe_pkg::PH_START, "sequencer mid-request with empty queue")

endmodule

/* hdl/dle_stuffed_frame_encoder_core.sv */
// Top level of the DLE byte-stuffing framer with additive checksum.
//
// Payload bytes enter on the s_ stream with s_tlast marking a frame's final byte; framed,
// stuffed line bytes leave on the m_ stream, m_tlast closing the bytes caused by one input
// and m_tuser flagging the end code. Each input yields 1 to 6 line bytes: a start code when
// it opens a frame, the byte itself or escape plus substitute (a second escape for an escape
// byte), and on the last byte the stuffed checksum and the end code. The output sequencer emits
// one line byte per cycle while m_tready does not stall it (2 line bytes for an escaped
// mid-frame byte, 1 for a plain mid-frame byte). A two-entry queue between input and output
// lets the input side keep accepting while the output waits; the first line byte of a request
// passes through the queue entry and then the output register. Write the code registers only
// while idle. Register map (byte addresses): 0x00 start, 0x04 end, 0x08 escape, 0x0C start
// substitute, 0x10 end substitute.
module dle_stuffed_frame_encoder_core
#(
    parameter int QUEUE_DEPTH = dsfe_pkg::QUEUE_DEPTH
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,    // [7:0] payload_byte
    input  logic                              s_tlast,    // frame_last
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [7:0]                        m_tdata,    // [7:0] line_byte
    output logic                              m_tlast,    // run_last
    output logic                              m_tuser,    // [0] frame_done
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [dsfe_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [dsfe_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [dsfe_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);

    dsfe_pkg::cfg_t  cfg;
    dsfe_pkg::desc_t push_desc;
    dsfe_pkg::desc_t head;
    logic            push;
    logic            pop;
    logic            q_valid;
    logic            q_full;

    dsfe_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dsfe_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .q_full    (q_full),
        .push      (push),
        .push_desc (push_desc)
    );

    dsfe_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .valid     (q_valid),
        .full      (q_full),
        .head      (head)
    );

    dsfe_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .q_valid  (q_valid),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
